### sv/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### sv/chs_pkg.sv
// Package with constants, types and the hash multiplier of the chained hash set.
package chs_pkg;
	localparam int BUCKETS    = 64;
	localparam int POOL_NODES = 256;
	localparam int KEY_BITS   = 32;
	localparam int BKT_W      = $clog2(BUCKETS);
	localparam int NODE_W     = $clog2(POOL_NODES);
	localparam int LINK_W     = $clog2(POOL_NODES + 1);
	localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_NODES);
	localparam logic [KEY_BITS-1:0] HASH_MUL = KEY_BITS'(64'd2654435761);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [KEY_BITS-1:0] key;
	} req_t;

	typedef struct packed {
		logic                ok;
		logic                full_res;
		logic [LINK_W-1:0]   key_count;
	} res_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_HEAD,
		ST_RDNODE,
		ST_CMP,
		ST_RDHIT,
		ST_FREE,
		ST_INS,
		ST_DONE
	} st_t;
endpackage

### sv/chs_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
module chs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### sv/chs_front.sv
// Front part: accepts requests into a short queue ahead of the table engine.
module chs_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  logic [1:0]     op,
	input  logic [chs_pkg::KEY_BITS-1:0] key,
	output logic           req_valid,
	output chs_pkg::req_t  req,
	input  logic           req_take
);
	localparam int DEPTH = 2;
	chs_pkg::req_t buf_q [DEPTH];
	logic          wr_q, rd_q;
	logic [1:0]    cnt_q;
	logic          do_push, do_pop;

	assign full      = (cnt_q == 2'(DEPTH));
	assign req_valid = (cnt_q != 2'd0);
	assign req       = buf_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = req_take && req_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_q] <= '{op: chs_pkg::op_t'(op), key: key};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	`include "assert_macros.svh"
	`ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= 2'(DEPTH))
	`ASSERT_NEXT(a_cnt_push, clk, arst_n, do_push && !do_pop, cnt_q == $past(cnt_q) + 2'd1)
	`ASSERT_NEXT(a_cnt_pop, clk, arst_n, do_pop && !do_push, cnt_q == $past(cnt_q) - 2'd1)
endmodule

### sv/chs_back.sv
// Back part: hashes, walks the bucket chain and updates the table.
module chs_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  chs_pkg::req_t  req,
	output logic           req_take,
	output logic           res_valid,
	output chs_pkg::res_t  res,
	input  logic           res_take
);
	localparam int BW = chs_pkg::BKT_W;
	localparam int NW = chs_pkg::NODE_W;
	localparam int LW = chs_pkg::LINK_W;
	localparam int KW = chs_pkg::KEY_BITS;

	chs_pkg::st_t st_q, st_d;
	chs_pkg::op_t op_q;
	logic [KW-1:0] key_q;
	logic [BW-1:0] bkt_q;
	logic [LW-1:0] cur_q, prev_q, free_q, count_q, hitlink_q, rcount_q;
	logic [LW-1:0] steps_q;
	logic [NW:0]   init_q;
	logic          found_q, ins_q;

	// Head memory, key memory, link memory.
	logic          h_we, k_we, l_we;
	logic [BW-1:0] h_wa, h_ra;
	logic [LW-1:0] h_wd, h_rd;
	logic [NW-1:0] k_wa, k_ra, l_wa, l_ra;
	logic [KW-1:0] k_wd, k_rd;
	logic [LW-1:0] l_wd, l_rd;

	chs_ram #(.WIDTH(LW), .DEPTH(chs_pkg::BUCKETS)) u_heads (
		.clk, .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
	chs_ram #(.WIDTH(KW), .DEPTH(chs_pkg::POOL_NODES)) u_keys (
		.clk, .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));
	chs_ram #(.WIDTH(LW), .DEPTH(chs_pkg::POOL_NODES)) u_links (
		.clk, .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));

	logic [KW-1:0] prod;
	logic [BW-1:0] bkt_hash;
	assign prod     = req.key * chs_pkg::HASH_MUL;
	assign bkt_hash = prod[BW-1:0];

	logic init_done;
	assign init_done = (init_q == (NW+1)'(chs_pkg::POOL_NODES));

	always_comb begin
		st_d = st_q;
		case (st_q)
			chs_pkg::ST_INIT: if (init_done) st_d = chs_pkg::ST_IDLE;
			chs_pkg::ST_IDLE: if (req_valid) st_d = chs_pkg::ST_HEAD;
			chs_pkg::ST_HEAD: st_d = chs_pkg::ST_RDNODE;
			chs_pkg::ST_RDNODE: begin
				if (cur_q == chs_pkg::NIL || steps_q == chs_pkg::NIL) begin
					st_d = (op_q == chs_pkg::OP_INSERT && free_q != chs_pkg::NIL) ?
						chs_pkg::ST_FREE : chs_pkg::ST_DONE;
				end else begin
					st_d = chs_pkg::ST_CMP;
				end
			end
			chs_pkg::ST_CMP: begin
				if (k_rd == key_q) begin
					st_d = (op_q == chs_pkg::OP_REMOVE) ? chs_pkg::ST_RDHIT : chs_pkg::ST_DONE;
				end else begin
					st_d = chs_pkg::ST_RDNODE;
				end
			end
			chs_pkg::ST_RDHIT: st_d = chs_pkg::ST_DONE;
			chs_pkg::ST_FREE:  st_d = chs_pkg::ST_INS;
			chs_pkg::ST_INS:   st_d = chs_pkg::ST_DONE;
			chs_pkg::ST_DONE:  if (!res_valid || res_take) st_d = chs_pkg::ST_IDLE;
			default: st_d = chs_pkg::ST_IDLE;
		endcase
	end

	// Memory controls per state.
	always_comb begin
		h_we = 1'b0; h_wa = bkt_q; h_wd = '0; h_ra = bkt_hash;
		k_we = 1'b0; k_wa = free_q[NW-1:0]; k_wd = key_q; k_ra = cur_q[NW-1:0];
		l_we = 1'b0; l_wa = '0; l_wd = '0; l_ra = cur_q[NW-1:0];
		req_take = 1'b0;
		case (st_q)
			chs_pkg::ST_INIT: begin
				l_we = !init_done;
				l_wa = init_q[NW-1:0];
				l_wd = LW'(init_q) + LW'(1);
				h_we = (init_q < (NW+1)'(chs_pkg::BUCKETS));
				h_wa = init_q[BW-1:0];
				h_wd = chs_pkg::NIL;
			end
			chs_pkg::ST_IDLE: req_take = req_valid;
			chs_pkg::ST_CMP: begin
				// A remove hit goes back on the free list; the read of its old
				// successor on this edge still returns the value before the write.
				if (k_rd == key_q && op_q == chs_pkg::OP_REMOVE) begin
					l_we = 1'b1;
					l_wa = cur_q[NW-1:0];
					l_wd = free_q;
				end
			end
			chs_pkg::ST_RDHIT: begin
				if (prev_q == chs_pkg::NIL) begin
					h_we = 1'b1;
					h_wd = l_rd;
				end else begin
					l_we = 1'b1;
					l_wa = prev_q[NW-1:0];
					l_wd = l_rd;
				end
			end
			chs_pkg::ST_FREE: l_ra = free_q[NW-1:0];
			chs_pkg::ST_INS: begin
				k_we = 1'b1;
				l_we = 1'b1;
				l_wa = free_q[NW-1:0];
				l_wd = hitlink_q;
				h_we = 1'b1;
				h_wd = free_q;
			end
			default: ;
		endcase
	end

	// Fields of the result register.
	logic ok_q, fullr_q;
	assign res       = '{ok: ok_q, full_res: fullr_q, key_count: rcount_q};

	always_ff @(posedge clk) begin
		case (st_q)
			chs_pkg::ST_IDLE: begin
				op_q  <= req.op;
				key_q <= req.key;
				bkt_q <= bkt_hash;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= chs_pkg::ST_INIT;
			init_q    <= '0;
			free_q    <= '0;
			count_q   <= '0;
			rcount_q  <= '0;
			cur_q     <= chs_pkg::NIL;
			prev_q    <= chs_pkg::NIL;
			hitlink_q <= chs_pkg::NIL;
			steps_q   <= '0;
			found_q   <= 1'b0;
			ins_q     <= 1'b0;
			res_valid <= 1'b0;
			ok_q      <= 1'b0;
			fullr_q   <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == chs_pkg::ST_DONE && (!res_valid || res_take)) begin
				res_valid <= 1'b1;
			end else if (res_take) begin
				res_valid <= 1'b0;
			end
			case (st_q)
				chs_pkg::ST_INIT: if (!init_done) init_q <= init_q + 1'b1;
				chs_pkg::ST_IDLE: begin
					prev_q  <= chs_pkg::NIL;
					steps_q <= '0;
					found_q <= 1'b0;
					ins_q   <= 1'b0;
				end
				chs_pkg::ST_HEAD: begin
					cur_q     <= h_rd;
					hitlink_q <= h_rd;
				end
				chs_pkg::ST_CMP: begin
					if (k_rd == key_q) begin
						found_q <= 1'b1;
					end else begin
						prev_q  <= cur_q;
						cur_q   <= l_rd;
						steps_q <= steps_q + 1'b1;
					end
				end
				chs_pkg::ST_RDHIT: free_q <= cur_q;
				chs_pkg::ST_FREE: ;
				chs_pkg::ST_INS: begin
					free_q  <= l_rd;
					count_q <= count_q + 1'b1;
					ins_q   <= 1'b1;
				end
				chs_pkg::ST_DONE: begin
					if (!res_valid || res_take) begin
						fullr_q <= (op_q == chs_pkg::OP_INSERT) && !found_q && !ins_q;
						case (op_q)
							chs_pkg::OP_INSERT: ok_q <= ins_q;
							chs_pkg::OP_SEARCH, chs_pkg::OP_REMOVE: ok_q <= found_q;
							default: ok_q <= 1'b0;
						endcase
						if (op_q == chs_pkg::OP_REMOVE && found_q && count_q != '0) begin
							count_q  <= count_q - 1'b1;
							rcount_q <= count_q - 1'b1;
						end else begin
							rcount_q <= count_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

	`include "assert_macros.svh"
	`ASSERT_IMP(a_take_idle, clk, arst_n, req_take, st_q == chs_pkg::ST_IDLE)
	`ASSERT_IMP(a_count_max, clk, arst_n, 1'b1, count_q <= chs_pkg::NIL)
	`ASSERT_NEXT(a_done_res, clk, arst_n, st_q == chs_pkg::ST_DONE && st_d == chs_pkg::ST_IDLE, res_valid)
endmodule

### sv/chained_hash_set.sv
// Top level of the chained hash set.
// Set of 32-bit keys in a 64-bucket separate-chaining table with a 256-node pool.
// After reset a clearing pass builds the free list; requests are held off
// meanwhile. A request then walks its bucket chain, reading one node key and
// link per step from memories with registered reads; one request is worked on
// at a time behind a two-entry queue, and a new result waits until the previous
// one has been taken.
module chained_hash_set (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  op,
	input  logic [31:0] key,
	output logic        empty,
	input  logic        pop,
	output logic        ok,
	output logic        full_res,
	output logic [8:0]  key_count
);
	logic          req_valid, req_take, res_valid;
	chs_pkg::req_t req;
	chs_pkg::res_t res;

	chs_front u_front (
		.clk, .arst_n, .push, .full, .op, .key,
		.req_valid, .req, .req_take);

	chs_back u_back (
		.clk, .arst_n, .req_valid, .req, .req_take,
		.res_valid, .res, .res_take(pop));

	assign empty     = !res_valid;
	assign ok        = res.ok;
	assign full_res  = res.full_res;
	assign key_count = res.key_count;
endmodule

### dv/testbench.sv
// Self-checking testbench for the chained hash set: directed and random requests with a scoreboard.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic       ok;
		logic       full_res;
		logic [8:0] key_count;
	} outcome_t;

	class set_scoreboard;
		logic [8:0]  heads[chs_pkg::BUCKETS];
		logic [31:0] keys[chs_pkg::POOL_NODES];
		logic [8:0]  links[chs_pkg::POOL_NODES];
		logic [8:0]  free_node;
		logic [8:0]  held;
		outcome_t    awaited[$];
		int          mismatches;

		function new();
			for (int i = 0; i < chs_pkg::BUCKETS; i++) heads[i] = 9'(chs_pkg::POOL_NODES);
			for (int i = 0; i < chs_pkg::POOL_NODES; i++) begin
				keys[i] = '0;
				links[i] = 9'(i + 1);
			end
			free_node = '0;
			held = '0;
			mismatches = 0;
		endfunction

		// Works out the outcome of one accepted request and queues it.
		function void note_request(chs_pkg::op_t code, logic [31:0] k);
			logic [31:0] prod;
			int          bkt;
			logic [8:0]  cur, prv, hit;
			outcome_t    res;
			prod = k * 32'd2654435761;
			bkt = int'(prod) & (chs_pkg::BUCKETS - 1);
			cur = heads[bkt];
			prv = 9'(chs_pkg::POOL_NODES);
			hit = 9'(chs_pkg::POOL_NODES);
			for (int s = 0; s < chs_pkg::POOL_NODES && cur < chs_pkg::POOL_NODES; s++) begin
				if (keys[cur] == k) begin
					hit = cur;
					break;
				end
				prv = cur;
				cur = links[cur];
			end
			if (hit == chs_pkg::POOL_NODES) prv = 9'(chs_pkg::POOL_NODES);
			res.ok = 1'b0;
			res.full_res = 1'b0;
			case (code)
				chs_pkg::OP_INSERT: begin
					if (hit == chs_pkg::POOL_NODES) begin
						if (free_node < chs_pkg::POOL_NODES) begin
							cur = free_node;
							free_node = links[cur];
							keys[cur] = k;
							links[cur] = heads[bkt];
							heads[bkt] = cur;
							held++;
							res.ok = 1'b1;
						end else begin
							res.full_res = 1'b1;
						end
					end
				end
				chs_pkg::OP_SEARCH: res.ok = (hit != chs_pkg::POOL_NODES);
				chs_pkg::OP_REMOVE: begin
					if (hit != chs_pkg::POOL_NODES) begin
						if (prv < chs_pkg::POOL_NODES) links[prv] = links[hit];
						else heads[bkt] = links[hit];
						links[hit] = free_node;
						free_node = hit;
						if (held > 0) held--;
						res.ok = 1'b1;
					end
				end
				default: ;
			endcase
			res.key_count = held;
			awaited.push_back(res);
		endfunction

		function void check_result(logic ok_v, logic full_v, logic [8:0] cnt_v);
			outcome_t exp_res;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result ok=%0b full=%0b count=%0d",
					ok_v, full_v, cnt_v);
				return;
			end
			exp_res = awaited.pop_front();
			if (ok_v !== exp_res.ok || full_v !== exp_res.full_res
					|| cnt_v !== exp_res.key_count) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"result mismatch: expected ok=%0b full=%0b count=%0d, ",
						"got ok=%0b full=%0b count=%0d"},
						exp_res.ok, exp_res.full_res, exp_res.key_count,
						ok_v, full_v, cnt_v);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  op = chs_pkg::OP_INSERT;
	logic [31:0] key = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic        ok;
	logic        full_res;
	logic [8:0]  key_count;

	set_scoreboard sb = new();
	bit            quiet = 1'b0;
	bit            hold_req = 1'b0;
	int            cycles = 0;
	logic [31:0]   pool_keys[512];

	chained_hash_set u_dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1_000_000) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// Sends one request; returns at the edge where it was transferred.
	task automatic send_request(chs_pkg::op_t code, logic [31:0] k);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		op <= code;
		key <= k;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_request(code, k);
	endtask

	// Result side: random stall bursts plus one long hold-off on request.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) sb.check_result(ok, full_res, key_count);
			if (hold_req) begin
				hold_req = 1'b0;
				pop <= 1'b0;
				for (int c = 0; c < 600; c++) @(posedge clk);
				pop <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 5);
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
				pop <= 1'b1;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		chs_pkg::op_t code;
		logic [31:0]  k;
		int           r, wait_cnt;
		for (int i = 0; i < 512; i++) begin
			pool_keys[i] = $urandom;
			// A quarter of the keys share buckets to build longer chains.
			if (i >= 384) pool_keys[i] = pool_keys[i - 384] + 32'($urandom_range(1, 8) * 64);
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extreme keys, duplicates, absent keys, unused op, chain unlinking.
		send_request(chs_pkg::OP_SEARCH, 32'h0);
		send_request(chs_pkg::OP_REMOVE, 32'hFFFF_FFFF);
		send_request(chs_pkg::OP_INSERT, 32'h0);
		send_request(chs_pkg::OP_INSERT, 32'hFFFF_FFFF);
		send_request(chs_pkg::OP_INSERT, 32'h0);
		send_request(chs_pkg::OP_SEARCH, 32'hFFFF_FFFF);
		send_request(chs_pkg::OP_NONE, 32'h0);
		send_request(chs_pkg::OP_NONE, 32'h1234_5678);
		send_request(chs_pkg::OP_INSERT, 32'd100);
		send_request(chs_pkg::OP_INSERT, 32'd164);
		send_request(chs_pkg::OP_INSERT, 32'd228);
		send_request(chs_pkg::OP_REMOVE, 32'd164);
		send_request(chs_pkg::OP_SEARCH, 32'd228);
		send_request(chs_pkg::OP_SEARCH, 32'd164);
		send_request(chs_pkg::OP_REMOVE, 32'd228);
		send_request(chs_pkg::OP_REMOVE, 32'd100);
		send_request(chs_pkg::OP_REMOVE, 32'd100);
		send_request(chs_pkg::OP_REMOVE, 32'h0);
		send_request(chs_pkg::OP_REMOVE, 32'hFFFF_FFFF);
		send_request(chs_pkg::OP_SEARCH, 32'hAAAA_5555);

		// Random: fill the pool past capacity, mix, then drain.
		for (int n = 0; n < 1600; n++) begin
			if (n == 60) hold_req = 1'b1;
			if (n >= 1400) quiet = 1'b1;
			r = $urandom_range(0, 99);
			if (n < 600) begin
				code = (r < 75) ? chs_pkg::OP_INSERT :
					(r < 90) ? chs_pkg::OP_SEARCH : chs_pkg::OP_REMOVE;
			end else if (n < 1100) begin
				code = (r < 35) ? chs_pkg::OP_INSERT :
					(r < 65) ? chs_pkg::OP_SEARCH : chs_pkg::OP_REMOVE;
			end else begin
				code = (r < 15) ? chs_pkg::OP_INSERT :
					(r < 35) ? chs_pkg::OP_SEARCH : chs_pkg::OP_REMOVE;
			end
			if (r == 99) code = chs_pkg::OP_NONE;
			k = ($urandom_range(0, 19) == 0) ? $urandom : pool_keys[$urandom_range(0, 511)];
			send_request(code, k);
		end
		push <= 1'b0;

		wait_cnt = 0;
		while (sb.awaited.size() != 0 && wait_cnt < 100000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (50) @(posedge clk);
		if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end
endmodule
